>>> sv/pfe_pkg.sv
package pfe_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int PTR_W = $clog2(STACK_DEPTH);
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);

	localparam logic [7:0] SYM_END  = 8'h23;
	localparam logic [7:0] SYM_ZERO = 8'h30;
	localparam logic [7:0] SYM_NINE = 8'h39;
	localparam logic [7:0] SYM_ADD  = 8'h2B;
	localparam logic [7:0] SYM_SUB  = 8'h2D;
	localparam logic [7:0] SYM_MUL  = 8'h2A;
	localparam logic [7:0] SYM_DIV  = 8'h2F;

	typedef enum logic [2:0] {
		OP_PUSH,
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV,
		OP_MOD,
		OP_END
	} op_t;

	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
	localparam logic [1:0] ERR_UNDERFLOW = 2'd2;
	localparam logic [1:0] ERR_DIVZERO   = 2'd3;

	typedef struct packed {
		op_t        op;
		logic [3:0] digit;
	} cmd_t;

	localparam int QDEPTH = 2;

endpackage

>>> sv/postfix_expression_evaluator.sv
// Postfix expression evaluator.
// The in channel (valid, stall, symbol) takes one ASCII character per
// transfer. Digits push 0..9; '+', '-', '*', '/' and any other non-'#'
// character (modulo) pop two values and push the result. On '#' one
// result leaves on the out channel (out_valid, out_stall, value, status).
// A two-entry queue decouples the decoder from the execution unit.
// Digits, '#', operators with fewer than two operands and anything after
// an error are handled in the idle state alone; '+', '-', '*' and a zero
// divisor pass through the wait, read and execute states (the first
// operand is read from the stack memory through its registered read
// port); '/' and modulo then run the one-bit-per-cycle restoring divider.
// The result of '#' appears the cycle after the execution unit takes it.
// While out_stall holds a result, the execution unit takes no new command
// and the queue fills, after which stall rises on the input.
// Reset empties the queue and the stack, clears the error and drops
// out_valid. The stack memory is not cleared.
module postfix_expression_evaluator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        stall,
	input  logic [7:0]  symbol,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [31:0] value,
	output logic [1:0]  status
);
	import pfe_pkg::*;

	logic  cmd_valid, cmd_take;
	cmd_t  cmd;
	logic [31:0] val_u;

	pfe_front u_front (
		.clk(clk), .arst_n(arst_n), .valid(valid), .stall(stall),
		.symbol(symbol), .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
	);

	pfe_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
		.cmd(cmd), .out_valid(out_valid), .out_stall(out_stall),
		.value(val_u), .status(status)
	);

	assign value = signed'(val_u);
endmodule

>>> sv/pfe_front.sv
module pfe_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid,
	output logic          stall,
	input  logic [7:0]    symbol,
	output logic          cmd_valid,
	input  logic          cmd_take,
	output pfe_pkg::cmd_t cmd
);
	import pfe_pkg::*;

	cmd_t       q_mem [QDEPTH];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	cmd_t       dec;
	logic       push, pop;

	always_comb begin
		dec.digit = 4'd0;
		if (symbol >= SYM_ZERO && symbol <= SYM_NINE) begin
			dec.op = OP_PUSH;
			dec.digit = 4'(symbol - SYM_ZERO);
		end else begin
			case (symbol)
				SYM_END: dec.op = OP_END;
				SYM_ADD: dec.op = OP_ADD;
				SYM_SUB: dec.op = OP_SUB;
				SYM_MUL: dec.op = OP_MUL;
				SYM_DIV: dec.op = OP_DIV;
				default: dec.op = OP_MOD;
			endcase
		end
	end

	assign stall     = (cnt_q == 2'(QDEPTH));
	assign push      = valid && !stall;
	assign cmd_valid = (cnt_q != 2'd0);
	assign pop       = cmd_valid && cmd_take;
	assign cmd       = q_mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) q_mem[wr_q] <= dec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'(QDEPTH))
		else $error("queue count out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 2'd1)
		else $error("queue count missed a write");
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd0 |-> !pop)
		else $error("read from empty queue");
endmodule

>>> sv/pfe_div.sv
module pfe_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic        done,
	output logic [31:0] quo,
	output logic [31:0] rem
);
	logic        busy_q;
	logic [5:0]  n_q;
	logic [31:0] q_q, r_q, d_q;
	logic        nq_q, nr_q;
	logic [32:0] trial;
	logic [31:0] r_sh;

	assign r_sh  = {r_q[30:0], q_q[31]};
	assign trial = {1'b0, r_sh} - {1'b0, d_q};
	assign quo   = nq_q ? -q_q : q_q;
	assign rem   = nr_q ? -r_q : r_q;

	always_ff @(posedge clk) begin
		if (start) begin
			q_q  <= a[31] ? -a : a;
			d_q  <= b[31] ? -b : b;
			r_q  <= 32'd0;
			nq_q <= a[31] ^ b[31];
			nr_q <= a[31];
		end else if (busy_q) begin
			if (!trial[32]) begin
				r_q <= trial[31:0];
				q_q <= {q_q[30:0], 1'b1};
			end else begin
				r_q <= r_sh;
				q_q <= {q_q[30:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			n_q <= 6'd0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				n_q <= 6'd0;
			end else if (busy_q) begin
				n_q <= n_q + 6'd1;
				if (n_q == 6'd31) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy_q)
		else $error("divider done while busy");
	assert property (@(posedge clk) disable iff (!arst_n) start |=> busy_q)
		else $error("divider did not start");
	assert property (@(posedge clk) disable iff (!arst_n) busy_q |-> !start)
		else $error("divider restarted while busy");
endmodule

>>> sv/pfe_back.sv
module pfe_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_take,
	input  pfe_pkg::cmd_t cmd,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [31:0]   value,
	output logic [1:0]    status
);
	import pfe_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_RD   = 5'b00010,
		ST_EXEC = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_WAIT = 5'b10000
	} state_t;

	state_t           state_q;
	logic [31:0]      mem [STACK_DEPTH];
	logic [CNT_W-1:0] cnt_q;
	logic [1:0]       err_q;
	cmd_t             cur_q;
	logic [31:0]      a_q, b_q, res;
	logic [31:0]      rd_data;
	logic [PTR_W-1:0] rd_addr;
	logic             wr_en;
	logic [PTR_W-1:0] wr_addr;
	logic [31:0]      wr_data;
	logic             div_start, div_done;
	logic [31:0]      quo, rem;
	logic             rd_b_q;
	logic [31:0]      prod;

	// Top of stack is cached in b_q; the entry below is read from memory.
	assign cmd_take = (state_q == ST_IDLE) && cmd_valid && !(out_valid && out_stall);
	assign prod = a_q * b_q;
	assign rd_addr = PTR_W'(cnt_q - CNT_W'(2));

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_data <= mem[rd_addr];
	end

	pfe_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .a(a_q), .b(b_q),
		.done(div_done), .quo(quo), .rem(rem)
	);

	always_comb begin
		case (cur_q.op)
			OP_ADD:  res = a_q + b_q;
			OP_SUB:  res = a_q - b_q;
			OP_MUL:  res = prod;
			OP_DIV:  res = quo;
			default: res = rem;
		endcase
	end

	always_comb begin
		wr_en = 1'b0;
		wr_addr = PTR_W'(cnt_q);
		wr_data = 32'(cmd.digit);
		div_start = 1'b0;
		if (cmd_take && cmd.op == OP_PUSH && err_q == ERR_NONE &&
		    cnt_q < CNT_W'(STACK_DEPTH))
			wr_en = 1'b1;
		if ((state_q == ST_EXEC && cur_q.op != OP_DIV && cur_q.op != OP_MOD) ||
		    (state_q == ST_DIV && div_done)) begin
			wr_en = 1'b1;
			wr_addr = PTR_W'(cnt_q - CNT_W'(2));
			wr_data = res;
		end
		if (state_q == ST_EXEC && (cur_q.op == OP_DIV || cur_q.op == OP_MOD) &&
		    b_q != 32'd0)
			div_start = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd_take) cur_q <= cmd;
		if (state_q == ST_RD) a_q <= rd_data;
		if (cmd_take && cmd.op == OP_PUSH) b_q <= 32'(cmd.digit);
		if (wr_en && state_q != ST_IDLE) b_q <= res;
		if (cmd_take && cmd.op == OP_END)
			value <= (err_q == ERR_NONE && cnt_q != '0) ? b_q : 32'd0;
		if (cmd_take && cmd.op == OP_END) status <= err_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			err_q <= ERR_NONE;
			out_valid <= 1'b0;
			rd_b_q <= 1'b0;
		end else begin
			out_valid <= (cmd_take && cmd.op == OP_END) || (out_valid && out_stall);
			rd_b_q <= cmd_take && cmd.op != OP_END && cmd.op != OP_PUSH &&
				err_q == ERR_NONE && cnt_q >= CNT_W'(2);
			case (state_q)
				ST_IDLE: begin
					if (cmd_take) begin
						if (cmd.op == OP_END) begin
							cnt_q <= '0;
							err_q <= ERR_NONE;
						end else if (err_q != ERR_NONE) begin
						end else if (cmd.op == OP_PUSH) begin
							if (cnt_q < CNT_W'(STACK_DEPTH)) cnt_q <= cnt_q + CNT_W'(1);
							else err_q <= ERR_OVERFLOW;
						end else if (cnt_q < CNT_W'(2)) begin
							err_q <= ERR_UNDERFLOW;
						end else begin
							state_q <= ST_WAIT;
						end
					end
				end
				ST_WAIT: state_q <= ST_RD;
				ST_RD: state_q <= ST_EXEC;
				ST_EXEC: begin
					if (cur_q.op == OP_DIV || cur_q.op == OP_MOD) begin
						if (b_q == 32'd0) begin
							err_q <= ERR_DIVZERO;
							state_q <= ST_IDLE;
						end else state_q <= ST_DIV;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
						state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						cnt_q <= cnt_q - CNT_W'(1);
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CNT_W'(STACK_DEPTH))
		else $error("stack count beyond depth");
	assert property (@(posedge clk) disable iff (!arst_n) state_q == ST_DIV |-> err_q == ERR_NONE)
		else $error("divide running after an error");
	assert property (@(posedge clk) disable iff (!arst_n) rd_b_q |-> state_q == ST_WAIT)
		else $error("operator did not start");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> cnt_q >= CNT_W'(2))
		else $error("operator with short stack");
endmodule

>>> tb/postfix_expression_evaluator_test.sv
module postfix_expression_evaluator_test;
	import pfe_pkg::*;

	typedef struct {
		logic signed [31:0] value;
		logic [1:0]         status;
	} outcome_t;

	logic               clk;
	logic               arst_n;
	logic               valid;
	logic               stall;
	logic [7:0]         symbol;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] value;
	logic [1:0]         status;

	postfix_expression_evaluator uut (
		.clk(clk),
		.arst_n(arst_n),
		.valid(valid),
		.stall(stall),
		.symbol(symbol),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.value(value),
		.status(status)
	);

	// Predicted state of the evaluator.
	logic [31:0] calc_stack [STACK_DEPTH];
	int          calc_depth;
	logic [1:0]  calc_error;
	outcome_t    pending_outcomes [$];

	int  mismatches;
	int  cycle_count;
	int  burst_left;
	bit  stall_pattern_on;
	bit  sender_hold;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic op_t decode_symbol(input logic [7:0] s);
		if (s == SYM_END)
			return OP_END;
		if (s >= SYM_ZERO && s <= SYM_NINE)
			return OP_PUSH;
		case (s)
			SYM_ADD: return OP_ADD;
			SYM_SUB: return OP_SUB;
			SYM_MUL: return OP_MUL;
			SYM_DIV: return OP_DIV;
			default: return OP_MOD;
		endcase
	endfunction

	task automatic evaluate_symbol(input logic [7:0] s);
		op_t                op;
		logic [31:0]        a;
		logic [31:0]        b;
		logic [31:0]        r;
		logic signed [31:0] sa;
		logic signed [31:0] sb;
		outcome_t           o;
		op = decode_symbol(s);
		if (op == OP_END) begin
			o.value = (calc_error == ERR_NONE && calc_depth > 0) ?
				calc_stack[calc_depth - 1] : 32'sd0;
			o.status = calc_error;
			pending_outcomes.push_back(o);
			calc_depth = 0;
			calc_error = ERR_NONE;
			return;
		end
		if (calc_error != ERR_NONE)
			return;
		if (op == OP_PUSH) begin
			if (calc_depth >= STACK_DEPTH)
				calc_error = ERR_OVERFLOW;
			else begin
				calc_stack[calc_depth] = 32'(s - SYM_ZERO);
				calc_depth++;
			end
			return;
		end
		if (calc_depth < 2) begin
			calc_error = ERR_UNDERFLOW;
			return;
		end
		b = calc_stack[calc_depth - 1];
		a = calc_stack[calc_depth - 2];
		sa = a;
		sb = b;
		case (op)
			OP_ADD: r = a + b;
			OP_SUB: r = a - b;
			OP_MUL: r = a * b;
			default: begin
				if (b == 0) begin
					calc_error = ERR_DIVZERO;
					return;
				end
				// The most negative value over -1 wraps; remainder is zero.
				if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF)
					r = (op == OP_DIV) ? a : 32'd0;
				else if (op == OP_DIV)
					r = sa / sb;
				else
					r = sa % sb;
			end
		endcase
		calc_depth -= 2;
		calc_stack[calc_depth] = r;
		calc_depth++;
	endtask

	// Sends one character as one transfer, with bursts and random gaps.
	task automatic send_symbol(input logic [7:0] s);
		if (burst_left == 0) begin
			valid = 1'b0;
			repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0)
				@(negedge clk);
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		valid = 1'b1;
		symbol = s;
		@(posedge clk);
		while (stall)
			@(posedge clk);
		evaluate_symbol(s);
		@(negedge clk);
		valid = 1'b0;
	endtask

	task automatic send_string(input string text);
		foreach (text[i])
			send_symbol(text[i]);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (pending_outcomes.size() != 0)
			@(negedge clk);
	endtask

	// Builds an expression of n operands; about one operator in ten is a random byte.
	task automatic send_random_expression(input int n);
		int  held;
		int  pushed;
		byte ops [4];
		ops = '{SYM_ADD, SYM_SUB, SYM_MUL, SYM_DIV};
		held = 0;
		pushed = 0;
		while (pushed < n || held > 1) begin
			if (pushed < n && (held < 2 || $urandom_range(0, 1))) begin
				send_symbol(SYM_ZERO + 8'($urandom_range(0, 9)));
				held++;
				pushed++;
			end else begin
				if ($urandom_range(0, 9) == 0)
					send_symbol(8'($urandom_range(0, 255)));
				else
					send_symbol(ops[$urandom_range(0, 3)]);
				held--;
			end
		end
		send_symbol(SYM_END);
	endtask

	task automatic test_directed();
		send_string("34+#");
		send_string("92-#");
		send_string("78*#");
		send_string("95/#");
		send_string("95%#");
		send_string("09-7%#");
		send_string("#");
		send_string("5+#");
		send_string("50/3#");
		send_string("40%#");
		send_symbol(8'h00);
		send_symbol(SYM_END);
		send_symbol(8'hFF);
		send_symbol(SYM_END);
	endtask

	task automatic test_wrap();
		// 9^10 overflows the signed 32-bit range; the last string ends in a '/' with one operand, which underflows.
		send_string("99*9*9*9*9*9*9*9*9*#");
		send_string("88*8*8*8*8*8*8*8*8*8*#");
		send_string("29*9*9*9*9*9*9*9*9*9*0-1-/#");
		wait_drained();
	endtask

	task automatic test_stack_limits();
		for (int i = 0; i < STACK_DEPTH; i++)
			send_symbol(SYM_ZERO + 8'(i % 10));
		send_symbol(SYM_END);
		for (int i = 0; i <= STACK_DEPTH; i++)
			send_symbol(SYM_ZERO + 8'(i % 10));
		send_symbol(SYM_ADD);
		send_symbol(SYM_END);
	endtask

	task automatic test_random();
		int sent;
		int n;
		sent = 0;
		while (sent < 1250) begin
			if ($urandom_range(0, 7) == 0) begin
				n = $urandom_range(1, 8);
				repeat (n)
					send_symbol(8'($urandom_range(0, 255)));
				send_symbol(SYM_END);
				sent += n + 1;
			end else begin
				n = $urandom_range(1, 8);
				send_random_expression(n);
				sent += 2 * n;
			end
			if ($urandom_range(0, 60) == 0) begin
				sender_hold = 1'b1;
				wait_drained();
				sender_hold = 1'b0;
			end
		end
	endtask

	always @(negedge clk) begin
		if ($urandom_range(0, 31) == 0)
			stall_pattern_on <= ~stall_pattern_on;
		out_stall <= stall_pattern_on ? ($urandom_range(0, 2) != 0) : 1'b0;
	end

	always @(posedge clk) begin
		outcome_t want;
		cycle_count++;
		if (cycle_count > 2000000) begin
			$display("CHECKS FAILED");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (pending_outcomes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result value=%0d status=%0d", value, status);
			end else begin
				want = pending_outcomes.pop_front();
				if (value !== want.value || status !== want.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected value=%0d status=%0d, got value=%0d status=%0d",
							want.value, want.status, value, status);
				end
			end
		end
	end

	initial begin
		valid = 1'b0;
		symbol = 8'h00;
		out_stall = 1'b0;
		stall_pattern_on = 1'b0;
		sender_hold = 1'b0;
		arst_n = 1'b0;
		calc_depth = 0;
		calc_error = ERR_NONE;
		mismatches = 0;
		cycle_count = 0;
		burst_left = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_wrap();
		test_stack_limits();
		test_random();
		wait_drained();
		repeat (50) @(negedge clk);
		if (mismatches == 0 && pending_outcomes.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
